### design/pool2d_pkg.sv
// ----------------------------------------------------------------------------
// pool2d_pkg
// Shared constants, configuration codes and helpers for the pooling core.
// ----------------------------------------------------------------------------
`default_nettype none

package pool2d_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_FILTER = 8;

    localparam int PIX_W   = 16;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int FILT_W  = 4;
    localparam int FIDX_W  = 3;
    localparam int LROW_W  = 3;
    localparam int ADDR_W  = LROW_W + POS_W;
    localparam int SUM_W   = 23;
    localparam int DIV_W   = 23;
    localparam int DVSR_W  = 7;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd6;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DIV_W-1:0]  quot;
        logic [DVSR_W-1:0] rem;
    } t_div_res;

    function automatic logic [FILT_W-1:0] clamp_filter(input logic [FILT_W-1:0] v);
        if (v == '0) begin
            return FILT_W'(1);
        end else if (v > FILT_W'(MAX_FILTER)) begin
            return FILT_W'(MAX_FILTER);
        end
        return v;
    endfunction

    function automatic logic [FILT_W-1:0] clamp_stride(input logic [FILT_W-1:0] v);
        return (v == '0) ? FILT_W'(1) : v;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### design/pool_2d_max_avg_forward_core.sv
// ----------------------------------------------------------------------------
// pool_2d_max_avg_forward_core
// Strided 2-D max / average pooling over a raster stream of Q8.8 pixels.
// ----------------------------------------------------------------------------
// One pixel is taken per item and written to the line store. A pixel that does
// not close a window goes back to idle after the check. A pixel that may close one
// runs the shared divider for the row and column phase, stopping early when
// the phase is off-grid, then twice more for the last window position,
// then reads fr*fc pixels from the line store one per cycle; average pooling
// adds one more divider pass. No pixel is taken while a window is worked on.
// The shared divider and the single line-store read port set the pace. The
// result waits in an output register while the next pixel is taken.
`default_nettype none

module pool_2d_max_avg_forward_core
    import pool2d_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [PIX_W-1:0]      s_axis_tdata,   // [15:0] pixel_value
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [15:0] pooled_value,
                                                       // [25:16] out_row,
                                                       // [35:26] out_col
    output logic                       m_axis_tlast    // last_of_image
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK, ST_DIVT, ST_DIVL, ST_DIVLR, ST_DIVLC,
        ST_SCAN, ST_DRAIN, ST_FIN, ST_AVG, ST_EMIT
    } t_state;

    t_state r_state;

    logic              r_mode;
    logic [FILT_W-1:0] r_cfg_fr, r_cfg_fc, r_cfg_sr, r_cfg_sc;
    logic [SIZE_W-1:0] r_cfg_rows, r_cfg_cols;

    logic [POS_W-1:0]  r_row_cnt, r_col_cnt;
    logic [POS_W-1:0]  r_r, r_c, r_top, r_left, r_orow, r_ocol, r_lrow;
    logic [FIDX_W-1:0] r_i, r_j;
    logic              r_rd_v;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [PIX_W-1:0] r_max;
    logic [PIX_W-1:0]  r_val;
    logic              r_last;

    logic              r_div_start;
    logic [DIV_W-1:0]  r_div_a;
    logic [DVSR_W-1:0] r_div_b;
    t_div_res          w_div;

    logic [PIX_W-1:0]  r_o_val;
    logic [POS_W-1:0]  r_o_row, r_o_col;
    logic              r_o_last;
    logic              r_o_valid;

    logic [FILT_W-1:0] w_fr, w_fc, w_sr, w_sc;
    logic [SIZE_W-1:0] w_rows, w_cols;
    logic              w_wrap, w_accept, w_cand;
    logic [POS_W-1:0]  w_er, w_ec;
    logic [SIZE_W-1:0] w_r1, w_c1;
    logic [ADDR_W-1:0] w_raddr;
    logic signed [PIX_W-1:0] w_rdata;
    logic [FIDX_W-1:0] w_ilast, w_jlast;
    logic [SUM_W-1:0]  w_abs;
    logic [DIV_W-1:0]  w_avg;

    assign w_fr   = clamp_filter(r_cfg_fr);
    assign w_fc   = clamp_filter(r_cfg_fc);
    assign w_sr   = clamp_stride(r_cfg_sr);
    assign w_sc   = clamp_stride(r_cfg_sc);
    assign w_rows = clamp_size(r_cfg_rows, SIZE_W'(MAX_ROWS));
    assign w_cols = clamp_size(r_cfg_cols, SIZE_W'(MAX_COLS));

    assign w_wrap = ({1'b0, r_row_cnt} >= w_rows) || ({1'b0, r_col_cnt} >= w_cols);
    assign w_er   = w_wrap ? '0 : r_row_cnt;
    assign w_ec   = w_wrap ? '0 : r_col_cnt;
    assign w_r1   = {1'b0, w_er} + SIZE_W'(1);
    assign w_c1   = {1'b0, w_ec} + SIZE_W'(1);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cand  = ({1'b0, r_r} + SIZE_W'(1) >= SIZE_W'(w_fr)) &&
                     ({1'b0, r_c} + SIZE_W'(1) >= SIZE_W'(w_fc));
    assign w_ilast = FIDX_W'(w_fr - FILT_W'(1));
    assign w_jlast = FIDX_W'(w_fc - FILT_W'(1));
    assign w_raddr = {LROW_W'(r_top + POS_W'(r_i)), POS_W'(r_left + POS_W'(r_j))};
    assign w_abs   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_avg   = r_sum[SUM_W-1] ? DIV_W'(-w_div.quot) : w_div.quot;

    pool2d_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr ({w_er[LROW_W-1:0], w_ec}),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pool2d_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_cfg_fr   <= FILT_W'(2);
            r_cfg_fc   <= FILT_W'(2);
            r_cfg_sr   <= FILT_W'(2);
            r_cfg_sc   <= FILT_W'(2);
            r_cfg_rows <= SIZE_W'(MAX_ROWS);
            r_cfg_cols <= SIZE_W'(MAX_COLS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_MODE:   r_mode     <= i_cfg_data[0];
                CFG_FILTER_ROWS: r_cfg_fr   <= i_cfg_data[FILT_W-1:0];
                CFG_FILTER_COLS: r_cfg_fc   <= i_cfg_data[FILT_W-1:0];
                CFG_STRIDE_ROWS: r_cfg_sr   <= i_cfg_data[FILT_W-1:0];
                CFG_STRIDE_COLS: r_cfg_sc   <= i_cfg_data[FILT_W-1:0];
                CFG_IMAGE_ROWS:  r_cfg_rows <= i_cfg_data;
                CFG_IMAGE_COLS:  r_cfg_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_div_start <= 1'b0;
            r_rd_v      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_rd_v      <= (r_state == ST_SCAN);
            if (m_axis_tready && (r_state != ST_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            if (r_rd_v) begin
                r_sum <= r_sum + SUM_W'(w_rdata);
                if (w_rdata > r_max) begin
                    r_max <= w_rdata;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_r <= w_er;
                        r_c <= w_ec;
                        if (w_c1 >= w_cols) begin
                            r_col_cnt <= '0;
                            r_row_cnt <= (w_r1 >= w_rows) ? '0 : w_r1[POS_W-1:0];
                        end else begin
                            r_col_cnt <= w_c1[POS_W-1:0];
                            r_row_cnt <= w_er;
                        end
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (w_cand) begin
                        r_top       <= POS_W'(r_r + POS_W'(1) - POS_W'(w_fr));
                        r_left      <= POS_W'(r_c + POS_W'(1) - POS_W'(w_fc));
                        r_div_a     <= DIV_W'(POS_W'(r_r + POS_W'(1) - POS_W'(w_fr)));
                        r_div_b     <= DVSR_W'(w_sr);
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIVT: begin
                    if (w_div.done) begin
                        if (w_div.rem != '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_orow      <= w_div.quot[POS_W-1:0];
                            r_div_a     <= DIV_W'(r_left);
                            r_div_b     <= DVSR_W'(w_sc);
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIVL;
                        end
                    end
                end
                ST_DIVL: begin
                    if (w_div.done) begin
                        if (w_div.rem != '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_ocol      <= w_div.quot[POS_W-1:0];
                            r_div_a     <= DIV_W'(w_rows - SIZE_W'(w_fr));
                            r_div_b     <= DVSR_W'(w_sr);
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIVLR;
                        end
                    end
                end
                ST_DIVLR: begin
                    if (w_div.done) begin
                        r_lrow      <= w_div.quot[POS_W-1:0];
                        r_div_a     <= DIV_W'(w_cols - SIZE_W'(w_fc));
                        r_div_b     <= DVSR_W'(w_sc);
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIVLC;
                    end
                end
                ST_DIVLC: begin
                    if (w_div.done) begin
                        r_last  <= (r_lrow == r_orow) &&
                                   (w_div.quot[POS_W-1:0] == r_ocol);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sum   <= '0;
                        r_max   <= {1'b1, {(PIX_W-1){1'b0}}};
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_j == w_jlast) begin
                        r_j <= '0;
                        r_i <= r_i + FIDX_W'(1);
                        if (r_i == w_ilast) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + FIDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (r_mode) begin
                        r_div_a     <= DIV_W'(w_abs);
                        r_div_b     <= DVSR_W'(w_fr) * DVSR_W'(w_fc);
                        r_div_start <= 1'b1;
                        r_state     <= ST_AVG;
                    end else begin
                        r_val   <= r_max;
                        r_state <= ST_EMIT;
                    end
                end
                ST_AVG: begin
                    if (w_div.done) begin
                        r_val   <= w_avg[PIX_W-1:0];
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_val   <= r_val;
                        r_o_last  <= r_last;
                        r_o_row   <= r_orow;
                        r_o_col   <= r_ocol;
                        r_o_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {4'b0, r_o_col, r_o_row, r_o_val};
    assign m_axis_tlast  = r_o_last;

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !w_div.busy)
        else $error("divider started while busy");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken before the first was processed");

    a_read_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> ($past(r_state) == ST_SCAN))
        else $error("store read data used outside a window scan");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_o_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result lost on emit");

endmodule

`default_nettype wire

### design/pool2d_store.sv
// ----------------------------------------------------------------------------
// pool2d_store
// Line store: the last MAX_FILTER rows of pixels, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pool2d_store
    import pool2d_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [ADDR_W-1:0]       i_waddr,
    input  wire logic signed [PIX_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0]       i_raddr,
    output logic signed [PIX_W-1:0]      o_rdata
);

    logic signed [PIX_W-1:0] r_mem [MAX_FILTER*MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/pool2d_div.sv
// ----------------------------------------------------------------------------
// pool2d_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pool2d_div
    import pool2d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_dividend,
    input  wire logic [DVSR_W-1:0] i_divisor,
    output t_div_res               o_res
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [DVSR_W:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? DVSR_W'(w_trial - {1'b0, r_dvsr}) : w_trial[DVSR_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], w_fit};
        end
    end

    assign o_res.done = r_done;
    assign o_res.busy = r_busy;
    assign o_res.quot = r_q;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the 2-D max / average pooling core.
// ----------------------------------------------------------------------------
// The run starts with a short table of directed configurations and pixels.
// Some rows carry a hand-typed expected window. Random phases follow. Each
// phase has its own window, stride, mode and image size, and feeds whole
// images. Some phases shrink the image mid-way so that the counters restart.
// Extreme sizes come last. A local line-store model predicts every
// window. Each output item is checked field by field against the oldest
// prediction. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import pool2d_pkg::*;

    localparam int WDOG_LIMIT  = 5000;
    localparam int SETTLE_CYC  = 300;
    localparam int RAND_ITEMS  = 200;
    localparam int WIDE_ITEMS  = 32;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_window;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pix;
        bit                    has_exp;
        t_window               exp;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    pool_2d_max_avg_forward_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // pooling model state
    logic signed [PIX_W-1:0] pix_lines [0:MAX_FILTER*MAX_COLS-1];
    int unsigned             pos_row;
    int unsigned             pos_col;
    logic                    reg_mode;
    logic [FILT_W-1:0]       reg_frows, reg_fcols, reg_srows, reg_scols;
    logic [SIZE_W-1:0]       reg_irows, reg_icols;

    t_window     pending_windows[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          windows_seen = 0;
    int          phases = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    int          rx_stall = 0;
    t_step       steps[$];

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit pool_pixel(logic [PIX_W-1:0] pix);
        int unsigned fr, fc, sr, sc, rows, cols, top, left, r, c;
        int          acc;
        t_window     w;
        bit          hit;
        fr   = clampu(reg_frows, 1, MAX_FILTER);
        fc   = clampu(reg_fcols, 1, MAX_FILTER);
        sr   = (reg_srows == 0) ? 1 : reg_srows;
        sc   = (reg_scols == 0) ? 1 : reg_scols;
        rows = clampu(reg_irows, 1, MAX_ROWS);
        cols = clampu(reg_icols, 1, MAX_COLS);
        hit  = 1'b0;
        if (pos_row >= rows || pos_col >= cols) begin
            pos_row = 0;
            pos_col = 0;
        end
        pix_lines[(pos_row % MAX_FILTER) * MAX_COLS + pos_col] = pix;
        if (pos_row + 1 >= fr && pos_col + 1 >= fc) begin
            top  = pos_row + 1 - fr;
            left = pos_col + 1 - fc;
            if (top % sr == 0 && left % sc == 0) begin
                acc = reg_mode ? 0 : pix_lines[(top % MAX_FILTER) * MAX_COLS + left];
                for (r = 0; r < fr; r++) begin
                    for (c = 0; c < fc; c++) begin
                        if (reg_mode)
                            acc += pix_lines[((top + r) % MAX_FILTER) * MAX_COLS + left + c];
                        else if (pix_lines[((top + r) % MAX_FILTER) * MAX_COLS + left + c] > acc)
                            acc = pix_lines[((top + r) % MAX_FILTER) * MAX_COLS + left + c];
                    end
                end
                if (reg_mode) acc = acc / int'(fr * fc);
                w.value = acc[PIX_W-1:0];
                w.row   = POS_W'(top / sr);
                w.col   = POS_W'(left / sc);
                w.last  = (top / sr == (rows - fr) / sr) && (left / sc == (cols - fc) / sc);
                pending_windows.push_back(w);
                hit = 1'b1;
            end
        end
        pos_col++;
        if (pos_col >= cols) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= rows) pos_row = 0;
        end
        return hit;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            windows_seen++;
            if (pending_windows.size() == 0) begin
                errors++;
                $display("%0t: unexpected window exp=none act=%h/%0d/%0d/%0d", $time,
                         m_axis_tdata[15:0], m_axis_tdata[25:16], m_axis_tdata[35:26],
                         m_axis_tlast);
            end else begin
                t_window w;
                w = pending_windows.pop_front();
                if (m_axis_tdata[15:0] !== w.value) begin
                    errors++;
                    $display("%0t: pooled_value exp=%h act=%h", $time, w.value,
                             m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[25:16] !== w.row) begin
                    errors++;
                    $display("%0t: out_row exp=%0d act=%0d", $time, w.row, m_axis_tdata[25:16]);
                end
                if (m_axis_tdata[35:26] !== w.col) begin
                    errors++;
                    $display("%0t: out_col exp=%0d act=%0d", $time, w.col, m_axis_tdata[35:26]);
                end
                if (m_axis_tlast !== w.last) begin
                    errors++;
                    $display("%0t: last_of_image exp=%0d act=%0d", $time, w.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d windows pending", $time,
                     pending_windows.size());
            $display("pool_2d_max_avg_forward_core verification failed");
            $finish;
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_pixel(logic [PIX_W-1:0] pix, output bit hit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        hit = pool_pixel(pix);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_POOL_MODE:   reg_mode  = data[0];
            CFG_FILTER_ROWS: reg_frows = data[FILT_W-1:0];
            CFG_FILTER_COLS: reg_fcols = data[FILT_W-1:0];
            CFG_STRIDE_ROWS: reg_srows = data[FILT_W-1:0];
            CFG_STRIDE_COLS: reg_scols = data[FILT_W-1:0];
            CFG_IMAGE_ROWS:  reg_irows = data;
            CFG_IMAGE_COLS:  reg_icols = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_all(logic m, int fr, int fc, int sr, int sc, int ir, int ic);
        write_reg(CFG_POOL_MODE, CFG_DATA_W'(m));
        write_reg(CFG_FILTER_ROWS, CFG_DATA_W'(fr));
        write_reg(CFG_FILTER_COLS, CFG_DATA_W'(fc));
        write_reg(CFG_STRIDE_ROWS, CFG_DATA_W'(sr));
        write_reg(CFG_STRIDE_COLS, CFG_DATA_W'(sc));
        write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(ir));
        write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(ic));
        phases++;
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = CFG_DATA_W'(data);
        steps.push_back(s);
    endtask

    task automatic add_pix(logic [PIX_W-1:0] pix);
        t_step s;
        s = '{default: '0};
        s.pix = pix;
        steps.push_back(s);
    endtask

    task automatic add_chk(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] v, int r, int c, bit l);
        t_step s;
        s = '{default: '0};
        s.pix     = pix;
        s.has_exp = 1'b1;
        s.exp     = '{value: v, row: POS_W'(r), col: POS_W'(c), last: l};
        steps.push_back(s);
    endtask

    task automatic feed_images(int n);
        int unsigned rows, cols;
        bit          hit;
        rows = clampu(reg_irows, 1, MAX_ROWS);
        cols = clampu(reg_icols, 1, MAX_COLS);
        repeat (n * rows * cols) send_pixel(rand_pixel(), hit);
    endtask

    function automatic int rand_filter();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return 0;
        if (p == 1) return $urandom_range(9, 15);
        if (p < 10) return $urandom_range(1, 3);
        return $urandom_range(1, 8);
    endfunction

    initial begin
        bit   hit, prev_cfg;
        int   start_pixels, ir, ic, k;
        t_step s;

        for (k = 0; k < MAX_FILTER * MAX_COLS; k++) pix_lines[k] = '0;
        pos_row = 0;
        pos_col = 0;
        reg_mode = 1'b0;
        reg_frows = 4'd2; reg_fcols = 4'd2; reg_srows = 4'd2; reg_scols = 4'd2;
        reg_irows = 11'd1024; reg_icols = 11'd1024;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // max pooling, 2x4 image, signed extremes
        add_cfg(CFG_IMAGE_ROWS, 2);
        add_cfg(CFG_IMAGE_COLS, 4);
        add_pix(16'h7FFF); add_pix(16'h8000); add_pix(16'h0001); add_pix(16'hFFFF);
        add_pix(16'h8000); add_chk(16'h0005, 16'h7FFF, 0, 0, 0);
        add_pix(16'hFFFE); add_chk(16'hFFFD, 16'h0001, 0, 1, 1);
        // average pooling, negative sums truncate toward zero
        add_cfg(CFG_POOL_MODE, 1);
        add_pix(16'hFFFF); add_pix(16'hFFFE); add_pix(16'h0003); add_pix(16'h0004);
        add_pix(16'hFFFF); add_chk(16'hFFFF, 16'hFFFF, 0, 0, 0);
        add_pix(16'h0004); add_chk(16'h0004, 16'h0003, 0, 1, 1);
        // zero and oversized filter, zero stride
        add_cfg(CFG_POOL_MODE, 0);
        add_cfg(CFG_FILTER_ROWS, 0);
        add_cfg(CFG_FILTER_COLS, 15);
        add_cfg(CFG_STRIDE_ROWS, 0);
        add_cfg(CFG_STRIDE_COLS, 0);
        add_cfg(CFG_IMAGE_ROWS, 1);
        add_cfg(CFG_IMAGE_COLS, 8);
        add_pix(16'hFFFB); add_pix(16'hFFFC); add_pix(16'h0009); add_pix(16'hFFFE);
        add_pix(16'h8000); add_pix(16'h0000); add_pix(16'h0001);
        add_chk(16'h0002, 16'h0009, 0, 0, 1);

        prev_cfg = 1'b0;
        foreach (steps[k]) begin
            s = steps[k];
            if (s.is_cfg) begin
                if (!prev_cfg) begin
                    drain();
                    phases++;
                end
                write_reg(s.idx, s.data);
            end else begin
                send_pixel(s.pix, hit);
                if (s.has_exp && (!hit || pending_windows[$].value !== s.exp.value ||
                                  pending_windows[$].row !== s.exp.row ||
                                  pending_windows[$].col !== s.exp.col ||
                                  pending_windows[$].last !== s.exp.last)) begin
                    errors++;
                    $display("%0t: table row %0d exp=%h/%0d/%0d/%0d act=%h/%0d/%0d/%0d",
                             $time, k, s.exp.value, s.exp.row, s.exp.col, s.exp.last,
                             pending_windows[$].value, pending_windows[$].row,
                             pending_windows[$].col, pending_windows[$].last);
                end
            end
            prev_cfg = s.is_cfg;
        end

        start_pixels = pixels_sent;
        while (pixels_sent - start_pixels < RAND_ITEMS) begin
            drain();
            quiet = ($urandom_range(0, 3) == 0);
            ir = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            ic = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            set_all(1'($urandom_range(0, 1)), rand_filter(), rand_filter(), rand_filter(),
                    rand_filter(), ir, ic);
            if ($urandom_range(0, 5) == 0 && ir > 2) begin
                // shrink mid-image so the counters fall outside and restart
                repeat ($urandom_range(reg_icols + 1, ir * (ic == 0 ? 1 : ic) - 1))
                    send_pixel(rand_pixel(), hit);
                drain();
                if (pos_row > 0) write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(pos_row));
                else write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(pos_col));
            end
            feed_images($urandom_range(1, 3));
        end

        quiet = 1'b0;
        drain();
        set_all(1'b1, 8, 8, 8, 8, 8, 8);
        for (k = 0; k < 128; k++) send_pixel(k < 64 ? 16'h8000 : 16'h7FFF, hit);
        drain();
        set_all(1'b1, 1, 1, 1, 1, 1, 2047);
        repeat (WIDE_ITEMS) send_pixel(rand_pixel(), hit);
        drain();
        set_all(1'b0, 1, 1, 1, 1, 1024, 1);
        repeat (WIDE_ITEMS) send_pixel(rand_pixel(), hit);
        drain();

        $display("Ran %0d pixels over %0d configurations, %0d windows checked.",
                 pixels_sent, phases, windows_seen);
        $display("Covered max and average modes, clamped sizes, restarts and 1024-pixel lines.");
        if (errors == 0) begin
            $display("pool_2d_max_avg_forward_core verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("pool_2d_max_avg_forward_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/pool2d_pkg.sv
design/pool2d_store.sv
design/pool2d_div.sv
design/pool_2d_max_avg_forward_core.sv
dv/tb_top.sv
